// File: hdl/cel_pkg.sv
// ----------------------------------------------------------------------------
// cel_pkg: shared definitions for the C expression lexer
// Token kinds, error codes, the result record and the record that the lexer
// front end hands to the result queue.
// ----------------------------------------------------------------------------
package cel_pkg;

  // Default longest line; columns saturate below it.
  localparam int unsigned MAX_LINE_DEFAULT = 4096;

  // Entries in the result queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Token kinds.
  localparam logic [2:0] KIND_OP     = 3'd0;
  localparam logic [2:0] KIND_IDENT  = 3'd1;
  localparam logic [2:0] KIND_NUMBER = 3'd2;
  localparam logic [2:0] KIND_STRING = 3'd3;
  localparam logic [2:0] KIND_CHAR   = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;
  localparam logic [2:0] KIND_EOL    = 3'd6;

  // Lexical error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OCT_DIG  = 2'd1;
  localparam logic [1:0] ERR_BARE_HEX = 2'd2;
  localparam logic [1:0] ERR_UNTERM   = 2'd3;

  // One result token.
  typedef struct packed {
    logic [2:0]        token_kind;
    logic [23:0]       op_text;
    logic [31:0]       number_value;
    logic signed [7:0] char_value;
    logic [11:0]       token_start;
    logic [11:0]       token_length;
    logic [1:0]        error_code;
    logic              last;
  } result_t;

  // Up to two results produced by one accepted input transaction.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Builds a result record; the last flag is set by the caller.
  function automatic result_t cel_result(logic [2:0] kind, logic [23:0] op,
                                         logic [31:0] num, logic [7:0] chv,
                                         logic [11:0] start, logic [11:0] len,
                                         logic [1:0] err);
    result_t r;
    r.token_kind   = kind;
    r.op_text      = op;
    r.number_value = num;
    r.char_value   = chv;
    r.token_start  = start;
    r.token_length = len;
    r.error_code   = err;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

// File: hdl/cel_if.sv
// ----------------------------------------------------------------------------
// cel_if: valid/ready channels of the C expression lexer
// cel_in_if carries one line character, cel_out_if carries one token result.
// ----------------------------------------------------------------------------
interface cel_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink   (input valid, input ch, input line_end, output ready);
endinterface

interface cel_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        token_kind;
  logic [23:0]       op_text;
  logic [31:0]       number_value;
  logic signed [7:0] char_value;
  logic [11:0]       token_start;
  logic [11:0]       token_length;
  logic [1:0]        error_code;
  logic              last;

  modport source (output valid, output token_kind, output op_text, output number_value,
                  output char_value, output token_start, output token_length,
                  output error_code, output last, input ready);
  modport sink   (input valid, input token_kind, input op_text, input number_value,
                  input char_value, input token_start, input token_length,
                  input error_code, input last, output ready);
endinterface

// File: hdl/cel_front.sv
// ----------------------------------------------------------------------------
// cel_front: lexer front end
// Accepts one character transaction per cycle while space_i is high, advances
// the token state machine and produces the zero, one or two results that it causes.
// ----------------------------------------------------------------------------
module cel_front #(
  parameter int unsigned MAX_LINE = cel_pkg::MAX_LINE_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cel_in_if.sink         in_i,
  input  logic           space_i,
  output cel_pkg::push_t push_o
);
  import cel_pkg::*;

  // Largest column value that is counted.
  localparam logic [11:0] ColMax = 12'((MAX_LINE - 1) < 4095 ? (MAX_LINE - 1) : 4095);

  typedef enum logic [4:0] {
    ST_INIT, ST_IDENT, ST_NUM0, ST_0X, ST_DEC, ST_OCT, ST_HEX, ST_SUF1, ST_SUF2,
    ST_VBAR, ST_AND, ST_NOT, ST_EQ, ST_LESS, ST_MORE, ST_PLUS, ST_MINUS, ST_SHARP,
    ST_STR, ST_ESC, ST_STRHEX, ST_DOT, ST_DOT2
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] value_q, value_d;
  logic [23:0] pending_q, pending_d;
  logic        quote_q, quote_d;
  logic [7:0]  char_q, char_d;
  logic [11:0] start_q, start_d;
  logic [11:0] len_q, len_d;
  logic [11:0] column_q, column_d;
  logic        drop_q, drop_d;

  logic        accept;
  logic [7:0]  c;
  logic        is_dig, is_alpha, is_hex, is_blank, pair_ok;
  logic [3:0]  hex_val;
  logic [11:0] len_inc;
  logic [31:0] dig_ext, hex_ext;
  state_e      eff;
  logic        redo;
  logic        run_init;
  result_t     res_a, res_b;
  logic [1:0]  n_res;

  assign in_i.ready = space_i;
  assign accept     = in_i.valid && space_i;
  assign c          = in_i.ch;

  // Character classes.
  assign is_dig   = (c >= "0") && (c <= "9");
  assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  assign is_hex   = is_dig || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  assign hex_val  = is_dig ? c[3:0] : 4'(c[3:0] + 4'd9);
  assign is_blank = (c == " ") || (c == 8'h09) || (c == 8'h0A);
  assign dig_ext  = {28'd0, c[3:0]};
  assign hex_ext  = {28'd0, hex_val};
  assign len_inc  = (len_q < 12'hFFF) ? 12'(len_q + 12'd1) : len_q;

  // Second character that completes a two-character operator.
  always_comb begin
    case (state_q)
      ST_VBAR:          pair_ok = (c == "|");
      ST_AND:           pair_ok = (c == "&");
      ST_NOT, ST_EQ:    pair_ok = (c == "=");
      ST_PLUS:          pair_ok = (c == "+");
      ST_MINUS:         pair_ok = (c == "-");
      ST_SHARP:         pair_ok = (c == "#");
      default:          pair_ok = (c == "=") || (c == pending_q[7:0]);
    endcase
  end

  // Token state machine: one character or end of line per transaction.
  always_comb begin
    state_d   = state_q;
    value_d   = value_q;
    pending_d = pending_q;
    quote_d   = quote_q;
    char_d    = char_q;
    start_d   = start_q;
    len_d     = len_q;
    column_d  = column_q;
    drop_d    = drop_q;
    eff       = state_q;
    redo      = 1'b0;
    run_init  = 1'b0;
    res_a     = '0;
    res_b     = '0;
    n_res     = 2'd0;

    if (accept) begin
      if (in_i.line_end) begin
        // Flush the pending token, then report end of line.
        if (!drop_q) begin
          case (state_q)
            ST_IDENT: begin
              res_a = cel_result(KIND_IDENT, '0, '0, '0, start_q, len_q, ERR_NONE);
              n_res = 2'd1;
            end
            ST_NUM0, ST_OCT, ST_DEC, ST_HEX, ST_SUF1, ST_SUF2: begin
              res_a = cel_result(KIND_NUMBER, '0, value_q, '0, start_q, len_q, ERR_NONE);
              n_res = 2'd1;
            end
            ST_0X: begin
              res_a = cel_result(KIND_ERROR, '0, '0, '0, start_q, len_q, ERR_BARE_HEX);
              n_res = 2'd1;
            end
            ST_STR, ST_ESC, ST_STRHEX: begin
              res_a = cel_result(KIND_ERROR, '0, '0, '0, start_q, len_q, ERR_UNTERM);
              n_res = 2'd1;
            end
            ST_VBAR, ST_AND, ST_NOT, ST_EQ, ST_LESS, ST_MORE, ST_PLUS, ST_MINUS,
            ST_SHARP, ST_DOT, ST_DOT2: begin
              res_a = cel_result(KIND_OP, pending_q, '0, '0, start_q, len_q, ERR_NONE);
              n_res = 2'd1;
            end
            default: ;
          endcase
        end
        if (n_res == 2'd1) begin
          res_b = cel_result(KIND_EOL, '0, '0, '0, column_q, '0, ERR_NONE);
          n_res = 2'd2;
        end else begin
          res_a = cel_result(KIND_EOL, '0, '0, '0, column_q, '0, ERR_NONE);
          n_res = 2'd1;
        end
        state_d  = ST_INIT;
        drop_d   = 1'b0;
        column_d = '0;
        len_d    = '0;
      end else begin
        if (!drop_q) begin
          // A non-hex character after a hex escape is taken up inside the literal.
          if ((state_q == ST_STRHEX) && !is_hex) begin
            eff = ST_STR;
          end
          case (eff)
            ST_INIT: run_init = 1'b1;
            ST_IDENT: begin
              if (is_alpha || is_dig) begin
                len_d = len_inc;
              end else if ((c == "\"") || (c == "'")) begin
                len_d   = len_inc;
                quote_d = (c == "'");
                char_d  = 8'hFF;
                state_d = ST_STR;
              end else begin
                res_a = cel_result(KIND_IDENT, '0, '0, '0, start_q, len_q, ERR_NONE);
                n_res = 2'd1;
                redo  = 1'b1;
              end
            end
            ST_NUM0: begin
              if ((c == "x") || (c == "X")) begin
                len_d   = len_inc;
                state_d = ST_0X;
              end else if ((c >= "0") && (c <= "7")) begin
                len_d   = len_inc;
                value_d = dig_ext;
                state_d = ST_OCT;
              end else if ((c == "8") || (c == "9")) begin
                res_a   = cel_result(KIND_ERROR, '0, '0, '0, start_q, len_inc, ERR_OCT_DIG);
                n_res   = 2'd1;
                drop_d  = 1'b1;
                state_d = ST_INIT;
              end else begin
                res_a = cel_result(KIND_NUMBER, '0, value_q, '0, start_q, len_q, ERR_NONE);
                n_res = 2'd1;
                redo  = 1'b1;
              end
            end
            ST_OCT: begin
              if ((c >= "0") && (c <= "7")) begin
                len_d   = len_inc;
                value_d = {value_q[28:0], 3'd0} + dig_ext;
              end else begin
                res_a = cel_result(KIND_NUMBER, '0, value_q, '0, start_q, len_q, ERR_NONE);
                n_res = 2'd1;
                redo  = 1'b1;
              end
            end
            ST_0X: begin
              if (is_hex) begin
                len_d   = len_inc;
                value_d = hex_ext;
                state_d = ST_HEX;
              end else begin
                res_a   = cel_result(KIND_ERROR, '0, '0, '0, start_q, len_inc, ERR_BARE_HEX);
                n_res   = 2'd1;
                drop_d  = 1'b1;
                state_d = ST_INIT;
              end
            end
            ST_HEX, ST_DEC: begin
              if ((eff == ST_HEX) && is_hex) begin
                len_d   = len_inc;
                value_d = {value_q[27:0], 4'd0} + hex_ext;
              end else if ((eff == ST_DEC) && is_dig) begin
                len_d   = len_inc;
                value_d = {value_q[28:0], 3'd0} + {value_q[30:0], 1'b0} + dig_ext;
              end else if ((c == "u") || (c == "U")) begin
                len_d   = len_inc;
                state_d = ST_SUF1;
              end else if ((c == "l") || (c == "L")) begin
                len_d   = len_inc;
                state_d = ST_SUF2;
              end else begin
                res_a = cel_result(KIND_NUMBER, '0, value_q, '0, start_q, len_q, ERR_NONE);
                n_res = 2'd1;
                redo  = 1'b1;
              end
            end
            ST_SUF1: begin
              if ((c == "l") || (c == "L")) begin
                len_d   = len_inc;
                state_d = ST_SUF2;
              end else begin
                res_a = cel_result(KIND_NUMBER, '0, value_q, '0, start_q, len_q, ERR_NONE);
                n_res = 2'd1;
                redo  = 1'b1;
              end
            end
            ST_SUF2: begin
              if ((c == "l") || (c == "L")) begin
                len_d   = len_inc;
                res_a   = cel_result(KIND_NUMBER, '0, value_q, '0, start_q, len_inc, ERR_NONE);
                n_res   = 2'd1;
                state_d = ST_INIT;
              end else begin
                res_a = cel_result(KIND_NUMBER, '0, value_q, '0, start_q, len_q, ERR_NONE);
                n_res = 2'd1;
                redo  = 1'b1;
              end
            end
            ST_DOT: begin
              if (c == ".") begin
                len_d     = len_inc;
                pending_d = pending_q | {8'd0, 8'h2E, 8'd0};
                state_d   = ST_DOT2;
              end else begin
                res_a = cel_result(KIND_OP, pending_q, '0, '0, start_q, len_q, ERR_NONE);
                n_res = 2'd1;
                redo  = 1'b1;
              end
            end
            ST_DOT2: begin
              len_d     = len_inc;
              pending_d = pending_q | {c, 16'd0};
              res_a     = cel_result(KIND_OP, pending_q | {c, 16'd0}, '0, '0, start_q,
                                     len_inc, ERR_NONE);
              n_res     = 2'd1;
              state_d   = ST_INIT;
            end
            ST_STR: begin
              len_d   = len_inc;
              state_d = ST_STR;
              if (!quote_q) begin
                if (c == "\"") begin
                  res_a   = cel_result(KIND_STRING, '0, '0, '0, start_q, len_inc, ERR_NONE);
                  n_res   = 2'd1;
                  state_d = ST_INIT;
                end else if (c == "\\") begin
                  state_d = ST_ESC;
                end
              end else begin
                if (c == "'") begin
                  res_a   = cel_result(KIND_CHAR, '0, '0, char_q, start_q, len_inc, ERR_NONE);
                  n_res   = 2'd1;
                  state_d = ST_INIT;
                end else if (c == "\\") begin
                  state_d = ST_ESC;
                end else begin
                  char_d = c;
                end
              end
            end
            ST_ESC: begin
              len_d = len_inc;
              if ((c == "x") || (c == "X")) begin
                state_d = ST_STRHEX;
              end else begin
                char_d  = c;
                state_d = ST_STR;
              end
            end
            ST_STRHEX: len_d = len_inc;
            ST_VBAR, ST_AND, ST_NOT, ST_EQ, ST_LESS, ST_MORE, ST_PLUS, ST_MINUS,
            ST_SHARP: begin
              if (pair_ok) begin
                len_d     = len_inc;
                pending_d = pending_q | {8'd0, c, 8'd0};
                res_a     = cel_result(KIND_OP, pending_q | {8'd0, c, 8'd0}, '0, '0,
                                       start_q, len_inc, ERR_NONE);
                n_res     = 2'd1;
                state_d   = ST_INIT;
              end else begin
                res_a = cel_result(KIND_OP, pending_q, '0, '0, start_q, len_q, ERR_NONE);
                n_res = 2'd1;
                redo  = 1'b1;
              end
            end
            default: run_init = 1'b1;
          endcase

          // Start of a new token; also runs for the character that ended the last one.
          if (run_init || redo) begin
            state_d = ST_INIT;
            if (!is_blank) begin
              start_d   = column_q;
              len_d     = 12'd1;
              value_d   = '0;
              char_d    = 8'hFF;
              pending_d = {16'd0, c};
              if (c == "0") begin
                state_d = ST_NUM0;
              end else if ((c >= "1") && (c <= "9")) begin
                value_d = dig_ext;
                state_d = ST_DEC;
              end else if (is_alpha) begin
                state_d = ST_IDENT;
              end else if (c == "\"") begin
                quote_d = 1'b0;
                state_d = ST_STR;
              end else if (c == "'") begin
                quote_d = 1'b1;
                state_d = ST_STR;
              end else if (c == "|") begin
                state_d = ST_VBAR;
              end else if (c == "&") begin
                state_d = ST_AND;
              end else if (c == "!") begin
                state_d = ST_NOT;
              end else if (c == "=") begin
                state_d = ST_EQ;
              end else if (c == "<") begin
                state_d = ST_LESS;
              end else if (c == ">") begin
                state_d = ST_MORE;
              end else if (c == "+") begin
                state_d = ST_PLUS;
              end else if (c == "-") begin
                state_d = ST_MINUS;
              end else if (c == "#") begin
                state_d = ST_SHARP;
              end else if (c == ".") begin
                state_d = ST_DOT;
              end else if (n_res == 2'd0) begin
                res_a = cel_result(KIND_OP, {16'd0, c}, '0, '0, column_q, 12'd1, ERR_NONE);
                n_res = 2'd1;
              end else begin
                res_b = cel_result(KIND_OP, {16'd0, c}, '0, '0, column_q, 12'd1, ERR_NONE);
                n_res = 2'd2;
              end
            end
          end
        end
        column_d = (column_q < ColMax) ? 12'(column_q + 12'd1) : column_q;
      end
    end

    // Mark the final result of this transaction.
    if (n_res == 2'd1) begin
      res_a.last = 1'b1;
    end else if (n_res == 2'd2) begin
      res_b.last = 1'b1;
    end
  end

  assign push_o.count  = n_res;
  assign push_o.first  = res_a;
  assign push_o.second = res_b;

  // Lexer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      value_q   <= '0;
      pending_q <= '0;
      quote_q   <= 1'b0;
      char_q    <= 8'hFF;
      start_q   <= '0;
      len_q     <= '0;
      column_q  <= '0;
      drop_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      value_q   <= value_d;
      pending_q <= pending_d;
      quote_q   <= quote_d;
      char_q    <= char_d;
      start_q   <= start_d;
      len_q     <= len_d;
      column_q  <= column_d;
      drop_q    <= drop_d;
    end
  end

endmodule

// File: hdl/cel_back.sv
// ----------------------------------------------------------------------------
// cel_back: result queue and output channel
// Stores up to two results per cycle from the front end and presents them on
// the output channel one transaction at a time, oldest first.
// ----------------------------------------------------------------------------
module cel_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cel_pkg::push_t push_i,
  output logic           space_o,
  cel_out_if.source      out_o
);
  import cel_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  result_t         entries_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;
  result_t         head;

  // Room for the largest burst one transaction can cause.
  assign space_o = (count_q <= CntW'(QUEUE_DEPTH - 2));
  assign pop     = out_o.valid && out_o.ready;
  assign head    = entries_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = PtrW'(wr_ptr_q + PtrW'(push_i.count));
    rd_ptr_d = pop ? PtrW'(rd_ptr_q + PtrW'(1)) : rd_ptr_q;
    count_d  = CntW'(count_q + CntW'(push_i.count) - CntW'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entries_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      entries_q[PtrW'(wr_ptr_q + PtrW'(1))] <= push_i.second;
    end
  end

  // Output channel.
  assign out_o.valid        = (count_q != '0);
  assign out_o.token_kind   = head.token_kind;
  assign out_o.op_text      = head.op_text;
  assign out_o.number_value = head.number_value;
  assign out_o.char_value   = head.char_value;
  assign out_o.token_start  = head.token_start;
  assign out_o.token_length = head.token_length;
  assign out_o.error_code   = head.error_code;
  assign out_o.last         = head.last;

endmodule

// File: hdl/c_expression_lexer.sv
// ----------------------------------------------------------------------------
// c_expression_lexer: streaming tokenizer for C preprocessor expressions
// Feed one character of a line per input transaction on in_i (ch, line_end);
// token results leave on out_o, each flagged last on the final result that
// its input character caused. A character causes zero, one or two results;
// line_end flushes the pending token and then reports end of line.
// Each result is written into the result queue when its character is accepted
// and appears on out_o once the older results ahead of it have left. Throughput:
// one character per cycle, as long as the four-entry result queue has two free
// entries; out_o delivers one result per cycle while out_o.ready is high, so a
// character that closes one token and opens a one-character operator yields
// two output transactions. When out_o stalls, the queue fills and in_i.ready
// drops until room returns; nothing is lost. Reset clears the lexer state, the
// column counter and the queue; in_i.ready is high as soon as reset is released.
// ----------------------------------------------------------------------------
module c_expression_lexer #(
  parameter int unsigned MAX_LINE = cel_pkg::MAX_LINE_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cel_in_if.sink    in_i,
  cel_out_if.source out_o
);
  import cel_pkg::*;

  push_t push;
  logic  space;

  // Front end: character classification and token state machine.
  cel_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .space_i (space),
    .push_o  (push)
  );

  // Back end: result queue and output channel.
  cel_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule
